### src/nrbt_pkg.sv
// Shared types and constants for the NACK receive bitmap tracker.
`default_nettype none
package nrbt_pkg;

  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned CNT_W  = 17;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned OFF_W  = 5;

  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_POLL   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ARR_RD,
    ST_ARR_CHK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic take;
    logic rd_en;
    logic rd_scan;
    logic arr_commit;
    logic scan_eval;
  } ctrl_t;

  typedef struct packed {
    logic clr_last;
    logic complete;
    logic scan_found;
    logic scan_end;
  } stat_t;

endpackage
`default_nettype wire

### src/nack_receive_bitmap_tracker.sv
// Top level of the NACK receive bitmap tracker.
//
//  channel   signals                                      transfer when
//  command   start, func_i, seq_num_i / busy              start && !busy
//  result    done_o, was_new_o, nack_valid_o, nack_seq_o,  done_o (one cycle)
//            complete_o, arrived_count_o
//  config    cfg_we_i, cfg_wdata_i (last_seq)             cfg_we_i
//
// Arrival: read, update, result, then idle before the next transfer.
// Poll: a read and a check per bitmap word of 32 bits, from the pointer up to
//   the first missing number or last_seq, over the one memory read port.
// Poll after completion: no bitmap read; it goes straight to the result.
// After reset a clearing pass writes ceil(min(MAX_PACKETS, 65536) / 32) words,
//   one per cycle, with busy high; configuration writes are taken meanwhile.
// Results cannot be stalled.
`default_nettype none
module nack_receive_bitmap_tracker
  import nrbt_pkg::*;
#(
  parameter int unsigned MAX_PACKETS = 65536
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             func_i,
  input  wire logic [SEQ_W-1:0] seq_num_i,
  input  wire logic             cfg_we_i,
  input  wire logic [SEQ_W-1:0] cfg_wdata_i,
  output logic                  done_o,
  output logic                  was_new_o,
  output logic                  nack_valid_o,
  output logic [SEQ_W-1:0]      nack_seq_o,
  output logic                  complete_o,
  output logic [CNT_W-1:0]      arrived_count_o
);

  ctrl_t ctrl;
  stat_t stat;

  nrbt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .busy   (busy),
    .done_o (done_o),
    .ctrl_o (ctrl),
    .stat_i (stat)
  );

  nrbt_dpath #(
    .MAX_PACKETS (MAX_PACKETS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .seq_num_i       (seq_num_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .was_new_o       (was_new_o),
    .nack_valid_o    (nack_valid_o),
    .nack_seq_o      (nack_seq_o),
    .complete_o      (complete_o),
    .arrived_count_o (arrived_count_o)
  );

endmodule
`default_nettype wire

### src/nrbt_ctrl.sv
// Controller state machine: clearing pass, arrival update and pointer scan sequencing.
`default_nettype none
module nrbt_ctrl
  import nrbt_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start,
  input  wire logic  func_i,
  output logic       busy,
  output logic       done_o,
  output ctrl_t      ctrl_o,
  input  wire stat_t stat_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ctrl_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl_o.take = 1'b1;
          if (func_i == FUNC_POLL) begin
            state_d = stat_i.complete ? ST_DONE : ST_SCAN_RD;
          end else begin
            state_d = ST_ARR_RD;
          end
        end
      end
      ST_ARR_RD: begin
        ctrl_o.rd_en = 1'b1;
        state_d      = ST_ARR_CHK;
      end
      ST_ARR_CHK: begin
        ctrl_o.arr_commit = 1'b1;
        state_d           = ST_DONE;
      end
      ST_SCAN_RD: begin
        ctrl_o.rd_en   = 1'b1;
        ctrl_o.rd_scan = 1'b1;
        state_d        = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        ctrl_o.scan_eval = 1'b1;
        if (stat_i.scan_found || stat_i.scan_end) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### src/nrbt_dpath.sv
// Datapath: bitmap memory, arrival count, scan pointer, word scan and result registers.
`default_nettype none
module nrbt_dpath
  import nrbt_pkg::*;
#(
  parameter int unsigned MAX_PACKETS = 65536
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ctrl_t            ctrl_i,
  output stat_t                 stat_o,
  input  wire logic [SEQ_W-1:0] seq_num_i,
  input  wire logic             cfg_we_i,
  input  wire logic [SEQ_W-1:0] cfg_wdata_i,
  output logic                  was_new_o,
  output logic                  nack_valid_o,
  output logic [SEQ_W-1:0]      nack_seq_o,
  output logic                  complete_o,
  output logic [CNT_W-1:0]      arrived_count_o
);

  localparam int unsigned DEPTH = (MAX_PACKETS < 65536) ? MAX_PACKETS : 65536;
  localparam int unsigned NW    = (DEPTH + WORD_W - 1) / WORD_W;
  localparam int unsigned AW    = (NW > 1) ? $clog2(NW) : 1;
  localparam logic [SEQ_W-1:0] TOP_MAX  = SEQ_W'(DEPTH - 1);
  localparam logic [AW-1:0]    ADDR_END = AW'(NW - 1);

  logic [WORD_W-1:0] mem_q [NW];
  logic [WORD_W-1:0] rdata_q;
  logic [AW-1:0]     clr_addr_q;
  logic [SEQ_W-1:0]  last_seq_q;
  logic [SEQ_W-1:0]  seq_q;
  logic [SEQ_W-1:0]  ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  cur_q;
  logic              was_new_q;
  logic              nack_valid_q;
  logic [SEQ_W-1:0]  nack_seq_q;

  logic [SEQ_W-1:0]  top;
  logic [CNT_W-1:0]  top_x;
  logic [CNT_W-1:0]  base;
  logic [AW-1:0]     arr_addr;
  logic [AW-1:0]     scan_addr;
  logic              arr_hit;
  logic [WORD_W-1:0] cand;
  logic              found;
  logic [OFF_W-1:0]  off;
  logic [SEQ_W-1:0]  hit_idx;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  assign top      = (last_seq_q < TOP_MAX) ? last_seq_q : TOP_MAX;
  assign top_x    = {1'b0, top};
  assign base     = {cur_q[CNT_W-1:OFF_W], {OFF_W{1'b0}}};
  assign arr_addr = AW'(seq_q[SEQ_W-1:OFF_W]);
  assign scan_addr = AW'(cur_q[CNT_W-1:OFF_W]);
  assign arr_hit  = (seq_q <= top) && !rdata_q[seq_q[OFF_W-1:0]];

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      cand[b] = !rdata_q[b] && (OFF_W'(b) >= cur_q[OFF_W-1:0])
                && ((base + CNT_W'(b)) <= top_x);
    end
  end

  always_comb begin
    found = 1'b0;
    off   = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        found = 1'b1;
        off   = OFF_W'(b);
      end
    end
  end

  assign hit_idx = base[SEQ_W-1:0] | {{(SEQ_W-OFF_W){1'b0}}, off};

  assign stat_o.clr_last   = (clr_addr_q == ADDR_END);
  assign stat_o.complete   = (cnt_q == ({1'b0, last_seq_q} + CNT_W'(1)));
  assign stat_o.scan_found = found;
  assign stat_o.scan_end   = ((base + CNT_W'(WORD_W - 1)) >= top_x);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = arr_addr;
    mem_wdata = rdata_q;
    if (ctrl_i.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else if (ctrl_i.arr_commit && arr_hit) begin
      mem_we = 1'b1;
      mem_wdata[seq_q[OFF_W-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[ctrl_i.rd_scan ? scan_addr : arr_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q   <= '0;
      last_seq_q   <= '0;
      ptr_q        <= SEQ_W'(1);
      cnt_q        <= '0;
      cur_q        <= '0;
      seq_q        <= '0;
      was_new_q    <= 1'b0;
      nack_valid_q <= 1'b0;
      nack_seq_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        last_seq_q <= cfg_wdata_i;
      end
      if (ctrl_i.clr_step) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (ctrl_i.take) begin
        seq_q        <= seq_num_i;
        cur_q        <= {1'b0, ptr_q};
        was_new_q    <= 1'b0;
        nack_valid_q <= 1'b0;
        nack_seq_q   <= '0;
      end
      if (ctrl_i.arr_commit && arr_hit) begin
        was_new_q <= 1'b1;
        cnt_q     <= cnt_q + CNT_W'(1);
      end
      if (ctrl_i.scan_eval) begin
        if (found) begin
          nack_valid_q <= 1'b1;
          nack_seq_q   <= hit_idx;
          ptr_q        <= (hit_idx >= last_seq_q) ? SEQ_W'(1) : hit_idx + SEQ_W'(1);
        end else if (stat_o.scan_end) begin
          ptr_q <= SEQ_W'(1);
        end else begin
          cur_q <= base + CNT_W'(WORD_W);
        end
      end
    end
  end

  assign was_new_o       = was_new_q;
  assign nack_valid_o    = nack_valid_q;
  assign nack_seq_o      = nack_seq_q;
  assign complete_o      = stat_o.complete;
  assign arrived_count_o = cnt_q;

endmodule
`default_nettype wire

### src/nrbt_checker.sv
// Port-level checker for the NACK receive bitmap tracker and its bind.
`default_nettype none
module nrbt_checker
  import nrbt_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             busy,
  input wire logic             done_o,
  input wire logic             was_new_o,
  input wire logic             nack_valid_o,
  input wire logic [SEQ_W-1:0] nack_seq_o,
  input wire logic             complete_o,
  input wire logic [CNT_W-1:0] arrived_count_o
);

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  a_new_xor_nack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(was_new_o && nack_valid_o))
    else $error("arrival and nack in one result");

  a_nack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !nack_valid_o) |-> (nack_seq_o == '0))
    else $error("nack_seq set without nack");

  a_nack_incomplete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && nack_valid_o) |-> (!complete_o && nack_seq_o != '0))
    else $error("nack after completion or for number zero");

  a_new_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && was_new_o) |-> (arrived_count_o != '0))
    else $error("new arrival with zero count");

endmodule

bind nack_receive_bitmap_tracker nrbt_checker u_nrbt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .busy            (busy),
  .done_o          (done_o),
  .was_new_o       (was_new_o),
  .nack_valid_o    (nack_valid_o),
  .nack_seq_o      (nack_seq_o),
  .complete_o      (complete_o),
  .arrived_count_o (arrived_count_o)
);
`default_nettype wire

### dv/nack_receive_bitmap_tracker_test.sv
// Self-checking testbench for the NACK receive bitmap tracker: directed and random transfers.
module nack_receive_bitmap_tracker_test;
  import nrbt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic             fn;
    logic [SEQ_W-1:0] sn;
  } rx_cmd_t;

  typedef struct packed {
    logic             was_new;
    logic             nack_valid;
    logic [SEQ_W-1:0] nack_seq;
    logic             complete;
    logic [CNT_W-1:0] arrived_count;
  } rx_report_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             func_i = FUNC_ARRIVE;
  logic [SEQ_W-1:0] seq_num_i = '0;
  logic             cfg_we_i = 1'b0;
  logic [SEQ_W-1:0] cfg_wdata_i = '0;
  logic             done_o;
  logic             was_new_o;
  logic             nack_valid_o;
  logic [SEQ_W-1:0] nack_seq_o;
  logic             complete_o;
  logic [CNT_W-1:0] arrived_count_o;

  nack_receive_bitmap_tracker u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .seq_num_i      (seq_num_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .was_new_o      (was_new_o),
    .nack_valid_o   (nack_valid_o),
    .nack_seq_o     (nack_seq_o),
    .complete_o     (complete_o),
    .arrived_count_o(arrived_count_o)
  );

  // Predictor state
  bit               seen_map [0:65535];
  logic [SEQ_W-1:0] scan_ptr = 16'd1;
  logic [CNT_W-1:0] arrivals = '0;
  logic [SEQ_W-1:0] last_seq_q = '0;

  rx_cmd_t    cmd_backlog[$];
  rx_report_t expected_reports[$];
  rx_cmd_t    next_cmd;
  rx_report_t got;
  rx_report_t want;
  int         idle_pct = 0;
  bit         hold_off = 1'b0;
  int         n_taken = 0;
  int         n_seen = 0;
  int         err_count = 0;
  int         cycles = 0;

  function automatic rx_report_t track_receipt(input logic fn, input logic [SEQ_W-1:0] sn);
    rx_report_t r;
    int i;
    r = '0;
    if (fn == FUNC_ARRIVE) begin
      if (sn <= last_seq_q && !seen_map[sn]) begin
        seen_map[sn] = 1'b1;
        arrivals = arrivals + 1'b1;
        r.was_new = 1'b1;
      end
    end else if (int'(arrivals) != int'(last_seq_q) + 1) begin
      i = int'(scan_ptr);
      while (i <= int'(last_seq_q) && seen_map[i]) i++;
      if (i <= int'(last_seq_q)) begin
        r.nack_valid = 1'b1;
        r.nack_seq = i[SEQ_W-1:0];
        scan_ptr = (i >= int'(last_seq_q)) ? 16'd1 : 16'(i + 1);
      end else begin
        scan_ptr = 16'd1;
      end
    end
    r.complete = (int'(arrivals) == int'(last_seq_q) + 1);
    r.arrived_count = arrivals;
    return r;
  endfunction

  task automatic report(input string msg);
    err_count++;
    if (err_count <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_reports.push_back(track_receipt(func_i, seq_num_i));
        n_taken++;
      end
      if (!start || !busy) begin
        if (hold_off && n_seen >= n_taken) begin
          hold_off = 1'b0;
        end else if (!hold_off && cmd_backlog.size() != 0 && $urandom_range(39) == 0) begin
          hold_off = 1'b1;
        end
        if (cmd_backlog.size() != 0 && !hold_off && $urandom_range(99) >= idle_pct) begin
          next_cmd = cmd_backlog.pop_front();
          start <= 1'b1;
          func_i <= next_cmd.fn;
          seq_num_i <= next_cmd.sn;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      got = '{was_new_o, nack_valid_o, nack_seq_o, complete_o, arrived_count_o};
      if (expected_reports.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        want = expected_reports.pop_front();
        if (got.was_new !== want.was_new)
          report($sformatf("was_new %b, want %b", got.was_new, want.was_new));
        if (got.nack_valid !== want.nack_valid)
          report($sformatf("nack_valid %b, want %b", got.nack_valid, want.nack_valid));
        if (got.nack_seq !== want.nack_seq)
          report($sformatf("nack_seq %0d, want %0d", got.nack_seq, want.nack_seq));
        if (got.complete !== want.complete)
          report($sformatf("complete %b, want %b", got.complete, want.complete));
        if (got.arrived_count !== want.arrived_count)
          report($sformatf("arrived_count %0d, want %0d", got.arrived_count,
                           want.arrived_count));
      end
      n_seen <= n_seen + 1;
    end
  end

  task automatic push_cmd(input logic fn, input int sn);
    rx_cmd_t c;
    c.fn = fn;
    c.sn = sn[SEQ_W-1:0];
    cmd_backlog.push_back(c);
  endtask

  task automatic push_poll();
    push_cmd(FUNC_POLL, $urandom_range(65535));
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (cmd_backlog.size() != 0 || start || n_seen < n_taken);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_last_seq(input int v);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[SEQ_W-1:0];
    last_seq_q = v[SEQ_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Send lo..hi in order, drop some, resend the dropped ones after NACK polls.
  task automatic queue_transfer(input int lo, input int hi);
    int lost[$];
    int s, j, k, tmp;
    for (s = lo; s <= hi; s++) begin
      if ($urandom_range(99) < 8) lost.push_back(s);
      else push_cmd(FUNC_ARRIVE, s);
      if ($urandom_range(99) < 30) push_poll();
      if ($urandom_range(99) < 6) push_cmd(FUNC_ARRIVE, $urandom_range(s));
      if ($urandom_range(99) < 5) push_cmd(FUNC_ARRIVE, $urandom_range(65535));
    end
    for (j = lost.size() - 1; j > 0; j--) begin
      k = $urandom_range(j);
      tmp = lost[j];
      lost[j] = lost[k];
      lost[k] = tmp;
    end
    foreach (lost[j]) begin
      push_poll();
      push_cmd(FUNC_ARRIVE, lost[j]);
    end
    push_poll();
    push_poll();
  endtask

  task automatic queue_mix(input int n, input int poll_pct, input int window);
    int j;
    for (j = 0; j < n; j++) begin
      if ($urandom_range(99) < poll_pct) push_poll();
      else if ($urandom_range(1) == 0) push_cmd(FUNC_ARRIVE, $urandom_range(65535));
      else push_cmd(FUNC_ARRIVE, $urandom_range(window));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // last_seq zero: one packet completes the transfer
    set_last_seq(0);
    push_poll();
    push_cmd(FUNC_ARRIVE, 0);
    push_cmd(FUNC_ARRIVE, 0);
    push_cmd(FUNC_ARRIVE, 1);
    push_cmd(FUNC_ARRIVE, 65535);
    push_poll();

    // gaps, pointer wrap and pointer beyond last_seq
    set_last_seq(5);
    push_cmd(FUNC_ARRIVE, 3);
    push_poll();
    push_poll();
    push_poll();
    set_last_seq(3);
    push_poll();
    push_poll();
    set_last_seq(5);
    push_poll();
    push_poll();
    push_poll();
    push_cmd(FUNC_ARRIVE, 1);
    push_cmd(FUNC_ARRIVE, 2);
    push_cmd(FUNC_ARRIVE, 4);
    push_cmd(FUNC_ARRIVE, 5);
    push_poll();

    set_last_seq(40);
    idle_pct = 0;
    queue_transfer(6, 40);

    set_last_seq(200);
    idle_pct = 75;
    queue_transfer(41, 200);

    set_last_seq(450);
    idle_pct = 0;
    queue_transfer(201, 450);

    set_last_seq(12);
    idle_pct = 28;
    queue_mix(40, 60, 20);

    set_last_seq(700);
    idle_pct = 75;
    queue_transfer(451, 700);

    set_last_seq(65535);
    idle_pct = 28;
    push_cmd(FUNC_ARRIVE, 65535);
    push_cmd(FUNC_ARRIVE, 65535);
    push_poll();
    queue_mix(300, 35, 800);

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (expected_reports.size() != 0)
      report($sformatf("%0d results never arrived", expected_reports.size()));
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
